/* design/assert_macros.svh */
// Assertion macros shared by the minimizer binning RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

/* design/mbin_pkg.sv */
// Types and constants shared by the minimizer binning modules.
// No dependencies.
`default_nettype none

package mbin_pkg;

  localparam int SYM_W = 8;
  localparam int LEN_W = 11;
  localparam int BIN_W = 30;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int K_W = 4;
  localparam int SKIP_W = 8;
  localparam int RUN_MAX = 15;
  localparam int K_MIN = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ZONE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_REV       = 2'd3;

  localparam logic [SYM_W-1:0] ASCII_A = 8'h41;
  localparam logic [SYM_W-1:0] ASCII_C = 8'h43;
  localparam logic [SYM_W-1:0] ASCII_G = 8'h47;
  localparam logic [SYM_W-1:0] ASCII_T = 8'h54;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef struct packed {
    logic             fwd_ok;
    logic             rev_ok;
    logic [BIN_W-1:0] fwd_code;
    logic [BIN_W-1:0] rev_code;
  } cand_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic             to_n_bin;
    logic             reverse_chosen;
  } res_t;

endpackage

`default_nettype wire

/* design/mbin_window.sv */
// Rolling forward and reverse-complement k-mers, run count and read position.
// Flags each step's windows as forward and reverse candidates. Uses mbin_pkg.
`default_nettype none

module mbin_window
  import mbin_pkg::*;
#(
  parameter int KMAX = 15,
  parameter int PW   = 10,
  parameter int PMAX = 1023
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [SYM_W-1:0]  sym,
  input  wire logic [LEN_W-1:0]  len,
  input  wire logic              last,
  input  wire logic [K_W-1:0]    k_eff,
  input  wire logic [SKIP_W-1:0] skip,
  output cand_t                  cand
);

  `include "assert_macros.svh"

  localparam int KW = 2 * KMAX;
  localparam int CW = ((PW > LEN_W) ? PW : LEN_W) + 2;
  localparam logic [PW-1:0] POS_LAST = PW'(PMAX);

  logic [KW-1:0]    fwd_r, fwd_nxt;
  logic [KW-1:0]    rev_r, rev_nxt;
  logic [K_W-1:0]   run_r, run_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [KW-1:0]    kmask;
  logic [KW-1:0]    fwd_sh, rev_sh;
  logic [1:0]       code;
  logic             sym_ok;
  logic             triple;
  logic [5:0]       grp;
  logic [CW-1:0]    p1;
  logic             fwd_in, rev_in, base_ok;

  always_comb begin
    case (sym)
      ASCII_A: begin code = BASE_A; sym_ok = 1'b1; end
      ASCII_C: begin code = BASE_C; sym_ok = 1'b1; end
      ASCII_G: begin code = BASE_G; sym_ok = 1'b1; end
      ASCII_T: begin code = BASE_T; sym_ok = 1'b1; end
      default: begin code = BASE_A; sym_ok = 1'b0; end
    endcase
  end

  always_comb begin
    for (int j = 0; j < KW; j++) begin
      kmask[j] = (j < 2 * int'(k_eff));
    end
    fwd_sh = {fwd_r[KW-3:0], code};
    rev_sh = rev_r >> 2;
    for (int j = 0; j < KMAX; j++) begin
      if (j == int'(k_eff) - 1) begin
        rev_nxt[2*j +: 2] = ~code;
      end else begin
        rev_nxt[2*j +: 2] = rev_sh[2*j +: 2];
      end
    end
    rev_nxt = rev_nxt & kmask;
    fwd_nxt = fwd_sh & kmask;
    run_nxt = (run_r == K_W'(RUN_MAX)) ? run_r : run_r + 1'b1;
  end

  always_comb begin
    triple = 1'b0;
    for (int i = 0; i + 3 <= KMAX; i++) begin
      grp = fwd_nxt[2*i +: 6];
      if ((i + 3 <= int'(k_eff)) && (grp[5:4] == grp[3:2]) && (grp[3:2] == grp[1:0])) begin
        triple = 1'b1;
      end
    end
  end

  always_comb begin
    p1      = CW'(pos_r) + 1'b1;
    fwd_in  = (p1 + CW'(skip)) <= CW'(len);
    rev_in  = (p1 >= (CW'(skip) + CW'(k_eff))) && (p1 <= CW'(len));
    base_ok = sym_ok && (run_nxt >= k_eff) && !triple;
    cand.fwd_ok   = base_ok && fwd_in;
    cand.rev_ok   = base_ok && rev_in;
    cand.fwd_code = BIN_W'(fwd_nxt);
    cand.rev_code = BIN_W'(rev_nxt);
    pos_nxt = (pos_r == POS_LAST) ? pos_r : pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= '0;
      rev_r <= '0;
      run_r <= '0;
      pos_r <= '0;
    end else if (step) begin
      if (last) begin
        fwd_r <= '0;
        rev_r <= '0;
        run_r <= '0;
        pos_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        if (sym_ok) begin
          fwd_r <= fwd_nxt;
          rev_r <= rev_nxt;
          run_r <= run_nxt;
        end else begin
          run_r <= '0;
        end
      end
    end
  end

  `ASSERT_NEXT(a_run_counts, step && sym_ok && !last, run_r != '0, "run count lost after a valid base")
  `ASSERT_NEXT(a_read_cleared, step && last, pos_r == '0 && run_r == '0, "window state not cleared")

endmodule

`default_nettype wire

/* design/mbin_minsel.sv */
// Per-read forward and reverse minimum tracking and the final bin choice.
// Takes candidates from mbin_window. Uses mbin_pkg.
`default_nettype none

module mbin_minsel
  import mbin_pkg::*;
#(
  parameter int KMAX = 15
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic           last,
  input  cand_t               cand,
  input  wire logic [K_W-1:0] s_eff,
  input  wire logic           use_rev,
  output res_t                res
);

  `include "assert_macros.svh"

  localparam int KW = 2 * KMAX;

  logic [KW-1:0] fmin_r, rmin_r, fmin_v, rmin_v;
  logic          ffound_r, rfound_r, ffound_v, rfound_v;
  logic [KW-1:0] fcode, rcode, smask, fm, rm;
  logic          ftake, rtake;

  always_comb begin
    fcode = KW'(cand.fwd_code);
    rcode = KW'(cand.rev_code);
    ftake = cand.fwd_ok && (!ffound_r || fcode < fmin_r);
    rtake = cand.rev_ok && (!rfound_r || rcode < rmin_r);
    fmin_v   = ftake ? fcode : fmin_r;
    rmin_v   = rtake ? rcode : rmin_r;
    ffound_v = ffound_r || ftake;
    rfound_v = rfound_r || rtake;
    for (int j = 0; j < KW; j++) begin
      smask[j] = (j < 2 * int'(s_eff));
    end
    fm = fmin_v & smask;
    rm = rmin_v & smask;
    if (use_rev && rfound_v && (!ffound_v || rm < fm)) begin
      res.bin_index      = BIN_W'(rm);
      res.to_n_bin       = 1'b0;
      res.reverse_chosen = 1'b1;
    end else if (ffound_v) begin
      res.bin_index      = BIN_W'(fm);
      res.to_n_bin       = 1'b0;
      res.reverse_chosen = 1'b0;
    end else begin
      res.bin_index      = '0;
      res.to_n_bin       = 1'b1;
      res.reverse_chosen = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmin_r   <= '0;
      rmin_r   <= '0;
      ffound_r <= 1'b0;
      rfound_r <= 1'b0;
    end else if (step) begin
      if (last) begin
        fmin_r   <= '0;
        rmin_r   <= '0;
        ffound_r <= 1'b0;
        rfound_r <= 1'b0;
      end else begin
        fmin_r   <= fmin_v;
        rmin_r   <= rmin_v;
        ffound_r <= ffound_v;
        rfound_r <= rfound_v;
      end
    end
  end

  `ASSERT_NEXT(a_found_cleared, step && last, !ffound_r && !rfound_r, "minimum flags not cleared")
  `ASSERT_CLK(a_fmin_zero, !ffound_r |-> fmin_r == '0, "forward minimum set without a candidate")

endmodule

`default_nettype wire

/* design/dna_read_minimizer_binning_core.sv */
// Top level of the read minimizer binning core: input register, configuration
// registers, output register. Uses mbin_pkg, mbin_window and mbin_minsel.
//
//   channel  direction  fields
//   in_      slave      tdata: symbol, read_length; tlast: last_symbol
//   out_     master     tdata: bin_index; tuser: to_n_bin, reverse_chosen
//   cfg_     write      index 0..3, data up to 8 bits
//
// One base beat is taken every cycle unless a last beat waits on a stalled result.
// A read's result is registered when its last base beat leaves the input register.
// rst_n is synchronous; it restores the register defaults and clears the read.
// A stalled result holds only the stage behind it when that stage has a last beat.
`default_nettype none

module dna_read_minimizer_binning_core
  import mbin_pkg::*;
#(
  parameter int MAX_SIGNATURE_LEN = 15,
  parameter int MAX_READ_LEN      = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // [7:0] symbol, [18:8] read_length
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [31:0]                out_tdata,  // [29:0] bin_index
  output logic [1:0]                 out_tuser,  // [0] to_n_bin, [1] reverse_chosen
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "assert_macros.svh"

  localparam int PW = $clog2(MAX_READ_LEN);

  logic [K_W-1:0]    sig_len_r, suf_len_r;
  logic [SKIP_W-1:0] skip_r;
  logic              use_rev_r;
  logic              v1_r;
  logic [SYM_W-1:0]  sym_r;
  logic [LEN_W-1:0]  len_r;
  logic              last_r;
  logic              out_valid_r;
  res_t              out_res_r;
  logic              out_free, s1_go;
  logic [K_W-1:0]    k_eff, s_eff;
  cand_t             cand;
  res_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_len_r <= K_W'(8);
      suf_len_r <= K_W'(8);
      skip_r    <= '0;
      use_rev_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIGNATURE_LEN: sig_len_r <= cfg_wdata[K_W-1:0];
        CFG_SUFFIX_LEN:    suf_len_r <= cfg_wdata[K_W-1:0];
        CFG_SKIP_ZONE:     skip_r    <= cfg_wdata[SKIP_W-1:0];
        CFG_USE_REV:       use_rev_r <= cfg_wdata[0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    if (sig_len_r < K_W'(K_MIN)) begin
      k_eff = K_W'(K_MIN);
    end else if (sig_len_r > K_W'(MAX_SIGNATURE_LEN)) begin
      k_eff = K_W'(MAX_SIGNATURE_LEN);
    end else begin
      k_eff = sig_len_r;
    end
    if (suf_len_r == '0) begin
      s_eff = K_W'(1);
    end else if (suf_len_r > k_eff) begin
      s_eff = k_eff;
    end else begin
      s_eff = suf_len_r;
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = v1_r && (!last_r || out_free);
  assign in_tready = !v1_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sym_r  <= in_tdata[SYM_W-1:0];
      len_r  <= in_tdata[SYM_W +: LEN_W];
      last_r <= in_tlast;
    end
  end

  mbin_window #(
    .KMAX (MAX_SIGNATURE_LEN),
    .PW   (PW),
    .PMAX (MAX_READ_LEN - 1)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .sym   (sym_r),
    .len   (len_r),
    .last  (last_r),
    .k_eff (k_eff),
    .skip  (skip_r),
    .cand  (cand)
  );

  mbin_minsel #(
    .KMAX (MAX_SIGNATURE_LEN)
  ) u_minsel (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .last    (last_r),
    .cand    (cand),
    .s_eff   (s_eff),
    .use_rev (use_rev_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.bin_index};
  assign out_tuser  = {out_res_r.reverse_chosen, out_res_r.to_n_bin};

  `ASSERT_CLK(a_nbin_clean, out_valid_r && out_res_r.to_n_bin |-> out_res_r.bin_index == '0 && !out_res_r.reverse_chosen, "N bin result carries data")
  `ASSERT_CLK(a_result_source, out_valid_r && !$past(out_valid_r) |-> $past(s1_go && last_r), "result without a last beat")
  `ASSERT_NEXT(a_last_waits, v1_r && last_r && !out_free, v1_r && $stable(sym_r), "last beat dropped while output full")

endmodule

`default_nettype wire
